FILE: rtl/core/lfo_pkg.sv
// Package for the sine LFO phase accumulator: action codes, register indexes,
// reset values and the elaboration-time quarter-wave sine table generator.
// Depends on nothing; the interface file and the top level import it.
package lfo_pkg;

    // Action codes carried by an input word.
    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_LOAD  = 2'd1,
        ACT_RESET = 2'd2
    } t_action;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_PHASE_STEP  = 2'd0,
        REG_DEPTH_GAIN  = 2'd1,
        REG_SYNC_ENABLE = 2'd2
    } t_reg_index;

    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned HOST_W     = 32;
    localparam int unsigned DEPTH_W    = 17;

    localparam logic [31:0]        STEP_RESET  = 32'd97391;
    localparam logic [DEPTH_W-1:0] DEPTH_RESET = 17'd32768;
    localparam logic [DEPTH_W-1:0] DEPTH_ONE   = 17'd65536;

    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Divisors (2k)(2k+1) of the nested Taylor terms, for k from 1 to 7.
    localparam logic [7:1][7:0] TAYLOR_DIV = {8'd210, 8'd156, 8'd110, 8'd72,
                                              8'd42, 8'd20, 8'd6};

    // sin(pi/2 * u) in Q30 for u in Q32, nested Taylor form up to z^15.
    function automatic logic [63:0] quarter_sine_q30(logic [63:0] u);
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] s;
        logic [63:0] t;
        z  = (u * HALF_PI_Q30) >> 32;
        z2 = (z * z) >> 30;
        s  = ONE_Q30;
        for (int k = 7; k >= 1; k--) begin
            t  = ((z2 * s) >> 30) / 64'(TAYLOR_DIV[k]);
            s  = (t >= ONE_Q30) ? 64'd0 : ONE_Q30 - t;
        end
        return (z * s) >> 30;
    endfunction

    // One entry of the quarter-wave table, rounded half up and capped at amp.
    function automatic logic [63:0] table_entry(logic [63:0] i, int unsigned tab_bits,
                                               logic [63:0] amp);
        logic [63:0] u;
        logic [63:0] v;
        u = i << (32 - tab_bits);
        v = (quarter_sine_q30(u) * amp + (ONE_Q30 >> 1)) >> 30;
        return (v > amp) ? amp : v;
    endfunction

endpackage

FILE: rtl/core/lfo_if.sv
// Stream and configuration interfaces of the sine LFO phase accumulator.
// Depends on lfo_pkg for the action code type and field widths.

// Input stream: one action word per handshake.
interface lfo_in_if
    import lfo_pkg::*;
();
    logic                valid;
    logic                ready;
    t_action             action;
    logic [HOST_W-1:0]   host_phase;

    modport source (output valid, output action, output host_phase, input ready);
    modport sink   (input valid, input action, input host_phase, output ready);
endinterface

// Output stream: one sample word per tick.
interface lfo_out_if #(
    parameter int SAMPLE_BITS = 16
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// Configuration write channel.
interface lfo_cfg_if
    import lfo_pkg::*;
();
    logic                   valid;
    logic                   ready;
    t_reg_index             index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/sine_lfo_phase_accumulator.sv
// Top level of the sine LFO: phase store, quarter-wave sine lookup, depth scaling
// and output queue. Depends on lfo_pkg, lfo_if.sv and lfo_ram.
//
// Usage:
//   i_in carries action words. A tick advances the phase by phase_step and yields
//   one sample on o_out; a load word copies host_phase into the phase when
//   sync_enable is set; a reset word clears the phase. Other words yield nothing.
//   i_cfg writes phase_step (0), depth_gain (1, low 17 bits clamped to 65536) and
//   sync_enable (2); it is always ready and is meant to be used while idle.
// Timing:
//   One word is accepted per cycle while i_in is ready. Samples pass the table
//   and product registers. The phase lives in a one-entry RAM read at accept and
//   written back from stage 1; a bypass register covers back-to-back words. The
//   sine table is a registered constant ROM, followed by one multiply stage.
// Stall:
//   Samples enter an eight-word queue. i_in stays ready while fewer than eight
//   samples are queued or in flight, so a stalled receiver blocks input only
//   after eight samples are pending. Nothing is lost or repeated.
// Reset:
//   i_rst_n (synchronous, active low) clears the phase, the pipeline and the
//   queue and loads the register reset values. No clearing pass is needed.
module sine_lfo_phase_accumulator
    import lfo_pkg::*;
#(
    parameter int PHASE_BITS      = 32,
    parameter int TABLE_ADDR_BITS = 10,
    parameter int SAMPLE_BITS     = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lfo_in_if.sink      i_in,
    lfo_out_if.source   o_out,
    lfo_cfg_if.sink     i_cfg
);
    localparam int TAB_N      = 1 << TABLE_ADDR_BITS;
    localparam int MAG_W      = SAMPLE_BITS - 1;
    localparam int PROD_W     = MAG_W + DEPTH_W;
    localparam int SCALED_W   = PROD_W + 1 - 16;
    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W      = 3;
    localparam int CNT_W      = 4;
    localparam logic [MAG_W-1:0] AMP = {MAG_W{1'b1}};

    typedef logic [MAG_W-1:0] t_tab [0:TAB_N];

    // Quarter-wave table built at elaboration.
    function automatic t_tab build_tab();
        t_tab tab;
        for (int i = 0; i <= TAB_N; i++) begin
            tab[i] = MAG_W'(table_entry(64'(i), TABLE_ADDR_BITS, 64'(AMP)));
        end
        return tab;
    endfunction

    localparam t_tab SINE_TAB = build_tab();

    // Configuration registers.
    logic [31:0]        r_step;
    logic [DEPTH_W-1:0] r_depth;
    logic               r_sync;
    logic [DEPTH_W-1:0] cfg_depth;

    assign i_cfg.ready = 1'b1;
    assign cfg_depth   = (i_cfg.data[DEPTH_W-1:0] > DEPTH_ONE) ? DEPTH_ONE
                                                                : i_cfg.data[DEPTH_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= STEP_RESET;
            r_depth <= DEPTH_RESET;
            r_sync  <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_PHASE_STEP:  r_step  <= i_cfg.data;
                REG_DEPTH_GAIN:  r_depth <= cfg_depth;
                REG_SYNC_ENABLE: r_sync  <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // Input acceptance and credit for samples queued or in flight.
    logic             in_acc;
    logic             out_pop;
    logic [CNT_W-1:0] r_credit;
    logic [CNT_W-1:0] n_credit;

    assign in_acc     = i_in.valid && i_in.ready;
    assign i_in.ready = (r_credit < CNT_W'(FIFO_DEPTH));
    assign out_pop    = o_out.valid && o_out.ready;

    always_comb begin
        n_credit = r_credit;
        if (in_acc && (i_in.action == ACT_TICK)) begin
            n_credit = n_credit + CNT_W'(1);
        end
        if (out_pop) begin
            n_credit = n_credit - CNT_W'(1);
        end
    end

    // Stage 1: the word whose phase is being read from the store.
    logic                  r_s1_vld;
    t_action               r_s1_act;
    logic [HOST_W-1:0]     r_s1_host;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_act  <= i_in.action;
            r_s1_host <= i_in.host_phase;
        end
    end

    // Phase store with bypass of a write that overlaps the next read.
    logic [PHASE_BITS-1:0] ph_rd;
    logic [PHASE_BITS-1:0] r_fwd;
    logic                  r_fwd_vld;
    logic                  r_ph_vld;
    logic [PHASE_BITS-1:0] cur_phase;
    logic [PHASE_BITS-1:0] n_phase;
    logic [PHASE_BITS+31:0] step_wide;
    logic [PHASE_BITS+31:0] host_wide;

    lfo_ram #(
        .WIDTH (PHASE_BITS),
        .DEPTH (1)
    ) u_phase_ram (
        .i_clk     (i_clk),
        .i_wr_en   (r_s1_vld),
        .i_wr_addr (1'b0),
        .i_wr_data (n_phase),
        .i_rd_en   (in_acc),
        .i_rd_addr (1'b0),
        .o_rd_data (ph_rd)
    );

    // Q0.32 values aligned to the phase width by a fixed shift.
    assign step_wide = {r_step, {PHASE_BITS{1'b0}}};
    assign host_wide = {r_s1_host, {PHASE_BITS{1'b0}}};

    always_comb begin
        if (r_fwd_vld) begin
            cur_phase = r_fwd;
        end else if (r_ph_vld) begin
            cur_phase = ph_rd;
        end else begin
            cur_phase = '0;
        end
        case (r_s1_act)
            ACT_TICK:  n_phase = cur_phase + step_wide[PHASE_BITS+31:32];
            ACT_LOAD:  n_phase = r_sync ? host_wide[PHASE_BITS+31:32] : cur_phase;
            ACT_RESET: n_phase = '0;
            default:   n_phase = cur_phase;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_vld <= 1'b0;
            r_ph_vld  <= 1'b0;
        end else begin
            r_fwd_vld <= r_s1_vld && in_acc;
            if (r_s1_vld) begin
                r_ph_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_fwd <= n_phase;
        end
    end

    // Quadrant folding into a table address.
    logic [1:0]                 quad;
    logic [TABLE_ADDR_BITS-1:0] idx;
    logic [TABLE_ADDR_BITS:0]   rom_addr;
    logic                       s1_tick;

    assign quad     = n_phase[PHASE_BITS-1 -: 2];
    assign idx      = n_phase[PHASE_BITS-3 -: TABLE_ADDR_BITS];
    assign rom_addr = quad[0] ? ((TABLE_ADDR_BITS+1)'(TAB_N) - {1'b0, idx}) : {1'b0, idx};
    assign s1_tick  = r_s1_vld && (r_s1_act == ACT_TICK);

    // Stage 2: registered table read.
    logic             r_s2_vld;
    logic             r_s2_neg;
    logic [MAG_W-1:0] r_s2_mag;

    // Stage 3: registered depth product.
    logic              r_s3_vld;
    logic              r_s3_neg;
    logic [PROD_W-1:0] r_s3_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            r_s2_vld <= s1_tick;
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_neg  <= quad[1];
        r_s2_mag  <= SINE_TAB[rom_addr];
        r_s3_neg  <= r_s2_neg;
        r_s3_prod <= PROD_W'(r_s2_mag) * PROD_W'(r_depth);
    end

    // Rounding, saturation and sign.
    logic [PROD_W:0]               round_sum;
    logic [SCALED_W-1:0]           scaled;
    logic [MAG_W-1:0]              mag_sat;
    logic signed [SAMPLE_BITS-1:0] sample;

    assign round_sum = {1'b0, r_s3_prod} + (PROD_W+1)'(32768);
    assign scaled    = round_sum[PROD_W:16];
    assign mag_sat   = (scaled > SCALED_W'(AMP)) ? AMP : scaled[MAG_W-1:0];
    assign sample    = r_s3_neg ? -$signed({1'b0, mag_sat}) : $signed({1'b0, mag_sat});

    // Output queue.
    logic [SAMPLE_BITS-1:0] r_fifo [0:FIFO_DEPTH-1];
    logic [PTR_W-1:0]       r_wr_ptr;
    logic [PTR_W-1:0]       r_rd_ptr;
    logic [CNT_W-1:0]       r_cnt;
    logic [CNT_W-1:0]       n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (r_s3_vld) begin
            n_cnt = n_cnt + CNT_W'(1);
        end
        if (out_pop) begin
            n_cnt = n_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
            r_credit <= '0;
        end else begin
            if (r_s3_vld) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (out_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_cnt    <= n_cnt;
            r_credit <= n_credit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s3_vld) begin
            r_fifo[r_wr_ptr] <= sample;
        end
    end

    assign o_out.valid  = (r_cnt != '0);
    assign o_out.sample = $signed(r_fifo[r_rd_ptr]);
endmodule

FILE: rtl/core/lfo_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the phase store of the LFO.
module lfo_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1,
    parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [ADDR_BITS-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]     i_wr_data,
    input  logic                 i_rd_en,
    input  logic [ADDR_BITS-1:0] i_rd_addr,
    output logic [WIDTH-1:0]     o_rd_data
);
    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port; a read at the write address sees old data.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule
